@@ src/lsps_pkg.sv @@
`default_nettype none
package lsps_pkg;

    localparam int MAP_CELLS_DEF  = 4096;
    localparam int PATH_MAX_DEF   = 1024;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [12:0]       WIDTH_RST  = 13'd64;
    localparam logic [12:0]       HEIGHT_RST = 13'd64;
    localparam logic signed [7:0] LIMIT_RST  = 8'sd20;
    localparam logic [3:0]        PASSES_RST = 4'd2;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_PASSES = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_PASS_START,
        S_COPY1,
        S_SRC0,
        S_CUR,
        S_LC_IDX,
        S_LC_RD,
        S_LC_CMP,
        S_BLOCK,
        S_ACC,
        S_END,
        S_DN_START,
        S_DN_FIRST,
        S_DN_NEXT,
        S_DN_WALK,
        S_PASS_END
    } state_t;

    typedef enum logic [1:0] {
        AS_ZERO,
        AS_ONE,
        AS_NEXT,
        AS_RP
    } addr_sel_t;

    typedef struct packed {
        logic      cost_wr;
        logic      append;
        logic      smooth_init;
        logic      finish;
        logic      pass_init;
        logic      copy1;
        logic      src0;
        logic      cur;
        logic      lc_step;
        logic      block;
        logic      acc;
        logic      end_wp;
        logic      dn_first;
        logic      dn_next;
        logic      dn_emit;
        logic      dn_adv;
        logic      set_ovf;
        logic      pass_end;
        logic      rd_start;
        logic      rd_finish;
        logic      wp_zero;
        addr_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic passes_zero;
        logic adj;
        logic inext_lt_n;
        logic walk_done;
        logic blocked;
        logic knext_lt_w;
        logic m_full;
        logic obuf_full;
    } stat_t;

endpackage
`default_nettype wire

@@ src/lsps_dp.sv @@
`default_nettype none
module lsps_dp #(
    parameter int MAP_CELLS  = 4096,
    parameter int PATH_MAX   = 1024,
    parameter int COORD_BITS = 12
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  lsps_pkg::cmd_t              cmd,
    output lsps_pkg::stat_t             stat,
    input  wire [12:0]                  map_width,
    input  wire [12:0]                  map_height,
    input  wire signed [7:0]            cost_limit,
    input  wire [3:0]                   pass_count,
    input  wire [11:0]                  cell_index,
    input  wire signed [7:0]            cell_cost,
    input  wire signed [COORD_BITS-1:0] point_x,
    input  wire signed [COORD_BITS-1:0] point_y,
    input  wire                         out_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic                        out_valid,
    output logic                        out_last,
    output logic                        out_overflow
);
    import lsps_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int MA = $clog2(MAP_CELLS);
    localparam int PA = $clog2(PATH_MAX);
    localparam int PW = $clog2(PATH_MAX + 1);
    localparam int EW = CB + 3;
    localparam int IW = 32;
    localparam int LW = 27;
    localparam logic signed [CB-1:0] ONE_C = CB'(1);

    typedef struct packed {
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] x;
    } pt_t;

    logic [7:0] cost_mem [MAP_CELLS];
    pt_t        ping_mem [PATH_MAX];
    pt_t        pong_mem [PATH_MAX];
    pt_t        wp_mem   [PATH_MAX];

    pt_t a_reg, p_reg, c_reg, q_reg;
    pt_t ping_rd_reg, pong_rd_reg, wp_rd_reg;
    logic signed [7:0] cost_rd_reg;
    logic [PW-1:0] i_reg, n_reg, w_reg, k_reg, m_reg, rp_reg;
    logic adj_reg, sel_reg, ready_reg, ovf_reg;
    logic [3:0] passes_reg;
    logic signed [CB-1:0] wx_reg, wy_reg, ex_reg, ey_reg;
    logic signed [EW-1:0] dx_reg, dy_reg, err_reg;
    logic sxn_reg, syn_reg;
    logic signed [IW-1:0] idx_reg;
    logic [LW-1:0] lim_reg;
    logic oor_reg;
    logic rd_ok_reg, rd_last_reg;
    logic obuf_full_reg;

    // Walker start and end points come from the anchor check or the waypoint fill.
    pt_t ia, ib, src_q;
    logic signed [CB:0] ddx, ddy, adx, ady;
    logic signed [EW-1:0] dx_init, dy_init;
    logic signed [EW:0] e2, dx_e, dy_e;
    logic go_x, go_y;
    logic signed [EW-1:0] err_step;
    logic signed [CB-1:0] nx, ny;
    logic walk_done;

    always_comb
    begin
        src_q   = sel_reg ? pong_rd_reg : ping_rd_reg;
        ia      = cmd.cur ? a_reg : q_reg;
        ib      = cmd.cur ? src_q : wp_rd_reg;
        ddx     = (CB+1)'(ib.x) - (CB+1)'(ia.x);
        ddy     = (CB+1)'(ib.y) - (CB+1)'(ia.y);
        adx     = ddx[CB] ? -ddx : ddx;
        ady     = ddy[CB] ? -ddy : ddy;
        dx_init = EW'(adx);
        dy_init = EW'(ady);
        e2      = $signed({err_reg, 1'b0});
        dx_e    = (EW+1)'(dx_reg);
        dy_e    = (EW+1)'(dy_reg);
        go_x    = e2 > -dy_e;
        go_y    = e2 < dx_e;
        err_step = err_reg - (go_x ? dy_reg : EW'(0)) + (go_y ? dx_reg : EW'(0));
        nx = go_x ? (sxn_reg ? wx_reg - ONE_C : wx_reg + ONE_C) : wx_reg;
        ny = go_y ? (syn_reg ? wy_reg - ONE_C : wy_reg + ONE_C) : wy_reg;
        walk_done = (wx_reg == ex_reg) && (wy_reg == ey_reg);
    end

    // Cell address and map bound.
    logic signed [CB+13:0] prod;
    logic [25:0] area;
    logic oor;
    assign prod = wy_reg * $signed({1'b0, map_width});
    assign area = map_width * map_height;
    assign oor  = (idx_reg < 0) || (idx_reg >= $signed(IW'(lim_reg)));

    always_ff @(posedge clk)
    begin
        idx_reg     <= IW'(prod) + IW'(wx_reg);
        lim_reg     <= (LW'(area) > LW'(MAP_CELLS)) ? LW'(MAP_CELLS) : LW'(area);
        oor_reg     <= oor;
        cost_rd_reg <= cost_mem[idx_reg[MA-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cost_wr && (IW'(cell_index) < IW'(MAP_CELLS)))
        begin
            cost_mem[MA'(cell_index)] <= cell_cost;
        end
    end

    // Path buffer ports.
    logic [PW-1:0] n_eff, i_inc, src_addr_w;
    logic [PA-1:0] src_addr, dst_addr, wp_waddr, wp_raddr;
    logic append_we, dst_we, ping_we, pong_we, wp_we;
    pt_t dst_data, wp_wdata, ping_wdata;
    logic [PA-1:0] ping_waddr;
    logic m_full;

    assign m_full    = m_reg >= PW'(PATH_MAX);
    assign n_eff     = ready_reg ? '0 : n_reg;
    assign append_we = cmd.append && (n_eff < PW'(PATH_MAX));
    assign i_inc     = i_reg + 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            AS_ZERO: src_addr_w = '0;
            AS_ONE:  src_addr_w = PW'(1);
            AS_NEXT: src_addr_w = i_inc;
            AS_RP:   src_addr_w = rp_reg;
            default: src_addr_w = '0;
        endcase
        src_addr = src_addr_w[PA-1:0];

        dst_we   = cmd.copy1 || cmd.dn_first || cmd.dn_emit;
        dst_addr = cmd.dn_emit ? m_reg[PA-1:0] : '0;
        if (cmd.copy1)
        begin
            dst_data = src_q;
        end
        else if (cmd.dn_first)
        begin
            dst_data = wp_rd_reg;
        end
        else
        begin
            dst_data = '{y: ny, x: nx};
        end

        ping_we    = append_we || (dst_we && sel_reg);
        pong_we    = dst_we && !sel_reg;
        ping_waddr = append_we ? n_eff[PA-1:0] : dst_addr;
        ping_wdata = append_we ? pt_t'{y: point_y, x: point_x} : dst_data;

        wp_we    = cmd.src0 || cmd.block || cmd.end_wp;
        wp_waddr = cmd.src0 ? '0 : w_reg[PA-1:0];
        wp_wdata = cmd.src0 ? src_q : p_reg;
        wp_raddr = cmd.wp_zero ? '0 : (k_reg[PA-1:0] + 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (ping_we)
        begin
            ping_mem[ping_waddr] <= ping_wdata;
        end
        if (pong_we)
        begin
            pong_mem[dst_addr] <= dst_data;
        end
        if (wp_we)
        begin
            wp_mem[wp_waddr] <= wp_wdata;
        end
        ping_rd_reg <= ping_mem[src_addr];
        pong_rd_reg <= pong_mem[src_addr];
        wp_rd_reg   <= wp_mem[wp_raddr];
    end

    // Points and walker registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.src0)
        begin
            a_reg <= src_q;
        end
        if (cmd.block)
        begin
            a_reg <= p_reg;
        end
        if (cmd.cur)
        begin
            c_reg <= src_q;
        end
        if (cmd.acc)
        begin
            p_reg <= c_reg;
        end
        if (cmd.dn_first)
        begin
            q_reg <= wp_rd_reg;
        end
        if (cmd.dn_next)
        begin
            q_reg <= wp_rd_reg;
        end
        if (cmd.cur || cmd.dn_next)
        begin
            wx_reg  <= ia.x;
            wy_reg  <= ia.y;
            ex_reg  <= ib.x;
            ey_reg  <= ib.y;
            dx_reg  <= dx_init;
            dy_reg  <= dy_init;
            err_reg <= dx_init - dy_init;
            sxn_reg <= !(ia.x < ib.x);
            syn_reg <= !(ia.y < ib.y);
        end
        else if (cmd.lc_step || cmd.dn_emit)
        begin
            wx_reg  <= nx;
            wy_reg  <= ny;
            err_reg <= err_step;
        end
        if (cmd.rd_start)
        begin
            rd_ok_reg   <= ready_reg && (rp_reg < n_reg);
            rd_last_reg <= (rp_reg + 1'b1) == n_reg;
        end
        if (cmd.rd_finish)
        begin
            out_x        <= rd_ok_reg ? src_q.x : '0;
            out_y        <= rd_ok_reg ? src_q.y : '0;
            out_valid    <= rd_ok_reg;
            out_last     <= rd_ok_reg && rd_last_reg;
            out_overflow <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            n_reg         <= '0;
            w_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            rp_reg        <= '0;
            adj_reg       <= 1'b0;
            sel_reg       <= 1'b0;
            ready_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            passes_reg    <= '0;
            obuf_full_reg <= 1'b0;
        end
        else
        begin
            if (cmd.append)
            begin
                if (ready_reg)
                begin
                    ready_reg <= 1'b0;
                    rp_reg    <= '0;
                    sel_reg   <= 1'b0;
                end
                if (append_we)
                begin
                    n_reg   <= n_eff + 1'b1;
                    ovf_reg <= ready_reg ? 1'b0 : ovf_reg;
                end
                else
                begin
                    n_reg   <= n_eff;
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.smooth_init)
            begin
                passes_reg <= pass_count;
            end
            if (cmd.finish)
            begin
                ready_reg <= 1'b1;
                rp_reg    <= '0;
            end
            if (cmd.pass_init)
            begin
                m_reg <= '0;
                k_reg <= '0;
                w_reg <= '0;
            end
            if (cmd.copy1)
            begin
                m_reg <= PW'(1);
            end
            if (cmd.src0)
            begin
                w_reg   <= PW'(1);
                i_reg   <= PW'(1);
                adj_reg <= 1'b1;
            end
            if (cmd.block || cmd.end_wp)
            begin
                w_reg <= w_reg + 1'b1;
            end
            if (cmd.acc)
            begin
                i_reg   <= i_inc;
                adj_reg <= 1'b0;
            end
            if (cmd.dn_first)
            begin
                m_reg <= PW'(1);
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.dn_adv)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.dn_emit)
            begin
                m_reg <= m_reg + 1'b1;
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.pass_end)
            begin
                n_reg      <= m_reg;
                sel_reg    <= !sel_reg;
                passes_reg <= passes_reg - 1'b1;
            end
            if (cmd.rd_start && ready_reg && (rp_reg < n_reg))
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (cmd.rd_finish)
            begin
                obuf_full_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                obuf_full_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.n_zero      = n_reg == '0;
        stat.n_one       = n_reg == PW'(1);
        stat.passes_zero = passes_reg == '0;
        stat.adj         = adj_reg;
        stat.inext_lt_n  = i_inc < n_reg;
        stat.walk_done   = walk_done;
        stat.blocked     = oor_reg || (cost_rd_reg > cost_limit);
        stat.knext_lt_w  = (k_reg + 1'b1) < w_reg;
        stat.m_full      = m_full;
        stat.obuf_full   = obuf_full_reg;
    end

endmodule
`default_nettype wire

@@ src/lsps_ctrl.sv @@
`default_nettype none
module lsps_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    input  wire [1:0]       req_type,
    input  wire             point_last,
    input  lsps_pkg::stat_t stat,
    output logic            s_tready,
    output lsps_pkg::cmd_t  cmd
);
    import lsps_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && !stat.obuf_full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_APPEND) && point_last)
                begin
                    state_next = S_PASS_START;
                end
                else if (accept && (req_type == REQ_READ))
                begin
                    state_next = S_RD_WAIT;
                end
            end
            S_RD_WAIT:    state_next = S_IDLE;
            S_PASS_START:
            begin
                if (stat.passes_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.n_zero)
                begin
                    state_next = S_PASS_END;
                end
                else if (stat.n_one)
                begin
                    state_next = S_COPY1;
                end
                else
                begin
                    state_next = S_SRC0;
                end
            end
            S_COPY1:      state_next = S_PASS_END;
            S_SRC0:       state_next = S_CUR;
            S_CUR:        state_next = stat.adj ? S_ACC : S_LC_IDX;
            S_LC_IDX:     state_next = S_LC_RD;
            S_LC_RD:      state_next = S_LC_CMP;
            S_LC_CMP:
            begin
                if (stat.blocked)
                begin
                    state_next = S_BLOCK;
                end
                else if (stat.walk_done)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_LC_IDX;
                end
            end
            S_BLOCK:      state_next = S_ACC;
            S_ACC:        state_next = stat.inext_lt_n ? S_CUR : S_END;
            S_END:        state_next = S_DN_START;
            S_DN_START:   state_next = S_DN_FIRST;
            S_DN_FIRST:   state_next = S_DN_NEXT;
            S_DN_NEXT:    state_next = S_DN_WALK;
            S_DN_WALK:
            begin
                if (stat.walk_done || stat.m_full)
                begin
                    state_next = stat.knext_lt_w ? S_DN_NEXT : S_PASS_END;
                end
            end
            S_PASS_END:   state_next = S_PASS_START;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.rd_sel = AS_RP;
                if (accept)
                begin
                    cmd.cost_wr     = req_type == REQ_WRITE;
                    cmd.append      = req_type == REQ_APPEND;
                    cmd.smooth_init = (req_type == REQ_APPEND) && point_last;
                    cmd.rd_start    = req_type == REQ_READ;
                end
            end
            S_RD_WAIT:    cmd.rd_finish = 1'b1;
            S_PASS_START:
            begin
                cmd.finish    = stat.passes_zero;
                cmd.pass_init = !stat.passes_zero;
                cmd.rd_sel    = AS_ZERO;
            end
            S_COPY1:      cmd.copy1 = 1'b1;
            S_SRC0:
            begin
                cmd.src0   = 1'b1;
                cmd.rd_sel = AS_ONE;
            end
            S_CUR:        cmd.cur = 1'b1;
            S_LC_CMP:     cmd.lc_step = !stat.blocked && !stat.walk_done;
            S_BLOCK:      cmd.block = 1'b1;
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                cmd.rd_sel = AS_NEXT;
            end
            S_END:        cmd.end_wp = 1'b1;
            S_DN_START:   cmd.wp_zero = 1'b1;
            S_DN_FIRST:   cmd.dn_first = 1'b1;
            S_DN_NEXT:    cmd.dn_next = 1'b1;
            S_DN_WALK:
            begin
                cmd.dn_emit = !stat.walk_done && !stat.m_full;
                cmd.set_ovf = !stat.walk_done && stat.m_full;
                cmd.dn_adv  = (stat.walk_done || stat.m_full) && stat.knext_lt_w;
            end
            S_PASS_END:   cmd.pass_end = 1'b1;
            default:      cmd = '0;
        endcase
    end

    // The read wait state always loads the result of the memory read into the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_WAIT) |-> cmd.rd_finish)
        else $error("read result not loaded");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_READ)) |=> (state_reg == S_RD_WAIT))
        else $error("read request lost");

    // A blocked line always makes a waypoint and then accepts the point.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BLOCK) |=> (state_reg == S_ACC))
        else $error("blocked line not resolved");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PASS_START) && stat.passes_zero) |=> (state_reg == S_IDLE))
        else $error("smoothing did not finish");

endmodule
`default_nettype wire

@@ src/line_of_sight_path_smoother.sv @@
`default_nettype none
// Map write and point append requests are taken in the idle state; a read request returns
// its result through the output register, and the block takes one request at a time.
// The last point starts pass_count passes; each line-of-sight cell test steps through
// the index, read and compare states, and each densified point is one walker step.
// Reset restores the default registers and an empty path; memories are not cleared.
module line_of_sight_path_smoother
    import lsps_pkg::*;
#(
    parameter int MAP_CELLS  = lsps_pkg::MAP_CELLS_DEF,
    parameter int PATH_MAX   = lsps_pkg::PATH_MAX_DEF,
    parameter int COORD_BITS = lsps_pkg::COORD_BITS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    // cell_index[11:0], cell_cost[7:0], point_x, point_y, zero fill
    input  wire [((24 + 2*COORD_BITS) + 7) / 8 * 8 - 1:0] s_tdata,
    // req_type[1:0]
    input  wire [1:0]           s_tuser,
    input  wire                 s_tlast,
    output logic                m_tvalid,
    input  wire                 m_tready,
    // out_x, out_y, zero fill
    output logic [(2*COORD_BITS + 7) / 8 * 8 - 1:0] m_tdata,
    // out_valid, out_overflow
    output logic [1:0]          m_tuser,
    output logic                m_tlast,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [1:0]           cfg_index,
    input  wire [12:0]          cfg_data
);
    localparam int CB     = COORD_BITS;
    localparam int OUT_DW = (2*CB + 7) / 8 * 8;

    logic [12:0]       width_reg, height_reg;
    logic signed [7:0] limit_reg;
    logic [3:0]        passes_reg;

    cmd_t  cmd;
    stat_t stat;

    logic signed [CB-1:0] out_x, out_y;
    logic out_valid, out_overflow;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            limit_reg  <= LIMIT_RST;
            passes_reg <= PASSES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_LIMIT:  limit_reg  <= cfg_data[7:0];
                CFG_PASSES: passes_reg <= cfg_data[3:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    lsps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .req_type   (s_tuser),
        .point_last (s_tlast),
        .stat       (stat),
        .s_tready   (s_tready),
        .cmd        (cmd)
    );

    lsps_dp #(
        .MAP_CELLS  (MAP_CELLS),
        .PATH_MAX   (PATH_MAX),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .map_width    (width_reg),
        .map_height   (height_reg),
        .cost_limit   (limit_reg),
        .pass_count   (passes_reg),
        .cell_index   (s_tdata[11:0]),
        .cell_cost    (s_tdata[19:12]),
        .point_x      (s_tdata[20 +: CB]),
        .point_y      (s_tdata[20 + CB +: CB]),
        .out_ready    (m_tready),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_valid    (out_valid),
        .out_last     (m_tlast),
        .out_overflow (out_overflow)
    );

    assign m_tvalid = stat.obuf_full;
    assign m_tdata  = OUT_DW'({out_y, out_x});
    assign m_tuser  = {out_overflow, out_valid};

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns/1ps
`default_nettype none
module tb;
    import lsps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int PATH_CAP = 1024;
    localparam int CELL_CAP = 4096;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic        vld;
        logic        lst;
        logic        ovf;
    } point_res_t;

    typedef struct {
        logic [1:0] req;
        int         idx;
        int         cost;
        int         x;
        int         y;
        bit         lst;
        bit         typed;
        point_res_t want;
    } plan_row_t;

    typedef struct {
        int x, y, ex, ey, dx, dy, sx, sy, err;
    } trace_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    line_of_sight_path_smoother dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow state of the smoother.
    int cost_map[CELL_CAP];
    int px[PATH_CAP], py[PATH_CAP];
    int qx[PATH_CAP], qy[PATH_CAP];
    int wx[PATH_CAP + 1], wy[PATH_CAP + 1];
    int n_pts, rd_ptr, m_out;
    bit ovf_f, ready_f;
    int map_w, map_h, lim_c, passes;

    point_res_t points_due[$];
    int errors;
    int cyc;
    int sent;
    int burst_left;
    int stall_ctr;
    int stall_mode;

    function automatic bit cell_hit(int x, int y);
        longint idx, lim;
        idx = longint'(y) * map_w + x;
        lim = longint'(map_w) * map_h;
        if (lim > CELL_CAP)
            lim = CELL_CAP;
        if (idx < 0 || idx >= lim)
            return 1;
        return cost_map[idx] > lim_c;
    endfunction

    function automatic trace_t trace_start(int ax, int ay, int bx, int by);
        trace_t t;
        t.x = ax; t.y = ay; t.ex = bx; t.ey = by;
        t.dx = bx > ax ? bx - ax : ax - bx;
        t.dy = by > ay ? by - ay : ay - by;
        t.sx = ax < bx ? 1 : -1;
        t.sy = ay < by ? 1 : -1;
        t.err = t.dx - t.dy;
        return t;
    endfunction

    function automatic trace_t trace_next(trace_t t);
        int e2;
        e2 = 2 * t.err;
        if (e2 > -t.dy)
        begin
            t.err -= t.dy;
            t.x += t.sx;
        end
        if (e2 < t.dx)
        begin
            t.err += t.dx;
            t.y += t.sy;
        end
        return t;
    endfunction

    function automatic bit sight_blocked(int ax, int ay, int bx, int by);
        trace_t t;
        t = trace_start(ax, ay, bx, by);
        while (1)
        begin
            if (cell_hit(t.x, t.y))
                return 1;
            if (t.x == t.ex && t.y == t.ey)
                return 0;
            t = trace_next(t);
        end
    endfunction

    function automatic void densify(int ax, int ay, int bx, int by);
        trace_t t;
        t = trace_start(ax, ay, bx, by);
        while (!(t.x == t.ex && t.y == t.ey))
        begin
            t = trace_next(t);
            if (m_out < PATH_CAP)
            begin
                qx[m_out] = t.x;
                qy[m_out] = t.y;
                m_out++;
            end
            else
            begin
                ovf_f = 1;
                return;
            end
        end
    endfunction

    function automatic void smooth_once();
        int w, a, i, k;
        if (n_pts <= 1)
            return;
        wx[0] = px[0];
        wy[0] = py[0];
        w = 1;
        a = 0;
        i = 1;
        while (i < n_pts)
        begin
            // Neighbouring points are always joined, even across a blocked cell.
            if (a + 1 == i || !sight_blocked(px[a], py[a], px[i], py[i]))
                i++;
            else
            begin
                wx[w] = px[i - 1];
                wy[w] = py[i - 1];
                w++;
                a = i - 1;
            end
        end
        wx[w] = px[n_pts - 1];
        wy[w] = py[n_pts - 1];
        w++;
        qx[0] = wx[0];
        qy[0] = wy[0];
        m_out = 1;
        for (k = 1; k < w; k++)
            densify(wx[k - 1], wy[k - 1], wx[k], wy[k]);
        for (k = 0; k < m_out; k++)
        begin
            px[k] = qx[k];
            py[k] = qy[k];
        end
        n_pts = m_out;
    endfunction

    function automatic void apply_request(logic [1:0] req, int idx, int cost, int x, int y,
                                          bit lst, output point_res_t r, output bit has);
        r = '0;
        has = 0;
        case (req)
            REQ_WRITE:
                cost_map[idx] = cost;
            REQ_APPEND:
            begin
                if (ready_f)
                begin
                    ready_f = 0;
                    n_pts = 0;
                    rd_ptr = 0;
                    ovf_f = 0;
                end
                if (n_pts < PATH_CAP)
                begin
                    px[n_pts] = x;
                    py[n_pts] = y;
                    n_pts++;
                end
                else
                    ovf_f = 1;
                if (lst)
                begin
                    repeat (passes) smooth_once();
                    rd_ptr = 0;
                    ready_f = 1;
                end
            end
            REQ_READ:
            begin
                has = 1;
                if (ready_f && rd_ptr < n_pts)
                begin
                    r.x = px[rd_ptr];
                    r.y = py[rd_ptr];
                    r.vld = 1;
                    r.lst = (rd_ptr + 1 == n_pts);
                    rd_ptr++;
                end
                r.ovf = ovf_f;
            end
            default:
                ;
        endcase
    endfunction

    always
    begin
        clk = 0;
        #5;
        clk = 1;
        #5;
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver switches between always ready, random stalls and a fixed stall rhythm.
    always @(negedge clk)
    begin
        stall_ctr++;
        if (stall_ctr % 97 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready = 1;
            1: m_tready = ($urandom_range(0, 3) != 0);
            default: m_tready = (stall_ctr % 7) >= 3;
        endcase
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        point_res_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (points_due.size() == 0)
            begin
                $error("result with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                w = points_due.pop_front();
                check_field("out_x", w.x, m_tdata[11:0]);
                check_field("out_y", w.y, m_tdata[23:12]);
                check_field("out_valid", w.vld, m_tuser[0]);
                check_field("out_overflow", w.ovf, m_tuser[1]);
                check_field("out_last", w.lst, m_tlast);
            end
        end
    end

    task automatic issue(input logic [1:0] req, input int idx, input int cost, input int x,
                         input int y, input bit lst, input bit typed = 0,
                         input point_res_t want = '0);
        logic [11:0] ib, xb, yb;
        logic [7:0]  cb;
        point_res_t  got;
        bit          has;
        int          gap;
        ib = idx;
        cb = cost;
        xb = x;
        yb = y;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tdata = {4'b0, yb, xb, cb, ib};
        s_tuser = req;
        s_tlast = lst;
        s_tvalid = 1;
        do @(posedge clk); while (!s_tready);
        apply_request(req, ib, $signed(cb), $signed(xb), $signed(yb), lst, got, has);
        if (has)
            points_due.push_back(typed ? want : got);
        if (req != REQ_SPARE)
            sent++;
    endtask

    // Stop the request stream and wait until every point has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid = 0;
        while (points_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input int val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_WIDTH:  map_w = val & 13'h1fff;
            CFG_HEIGHT: map_h = val & 13'h1fff;
            CFG_LIMIT:  lim_c = $signed(8'(val));
            default:    passes = val & 4'hf;
        endcase
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic read_out(input int count);
        repeat (count) issue(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom % 2);
    endtask

    task automatic random_path();
        int k, j, cx, cy, reads;
        k = $urandom_range(1, 12);
        cx = $urandom_range(0, 40);
        cy = $urandom_range(0, 40);
        for (j = 0; j < k; j++)
        begin
            if ($urandom_range(0, 9) == 0)
                issue(REQ_WRITE, $urandom_range(0, 4095), $signed(8'($urandom)),
                      $urandom, $urandom, $urandom % 2);
            if ($urandom_range(0, 14) == 0)
                read_out(1);
            if ($urandom_range(0, 19) == 0)
                issue(REQ_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom % 2);
            if ($urandom_range(0, 39) == 0)
            begin
                cx = $signed(12'($urandom));
                cy = $signed(12'($urandom));
            end
            else
            begin
                cx += $signed($urandom_range(0, 8)) - 4;
                cy += $signed($urandom_range(0, 8)) - 4;
                if (cx < -2048 || cx > 2047)
                    cx = 10;
                if (cy < -2048 || cy > 2047)
                    cy = 10;
            end
            issue(REQ_APPEND, $urandom, $urandom, cx, cy, j == k - 1);
        end
        reads = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_pts) : n_pts + 1;
        if (reads > 100)
            reads = 100;
        read_out(reads);
    endtask

    initial
    begin
        plan_row_t plan[$];
        plan_row_t row;
        int i, ph, saved, paths;
        point_res_t none;

        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = REQ_WRITE;
        s_tlast = 0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        errors = 0;
        cyc = 0;
        burst_left = 0;
        stall_ctr = 0;
        stall_mode = 0;
        n_pts = 0;
        rd_ptr = 0;
        ovf_f = 0;
        ready_f = 0;
        map_w = WIDTH_RST;
        map_h = HEIGHT_RST;
        lim_c = LIMIT_RST;
        passes = PASSES_RST;
        none = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Load every cell so that no line ever reads an unwritten one.
        for (i = 0; i < CELL_CAP; i++)
            issue(REQ_WRITE, i, ($urandom_range(0, 6) == 0) ? $urandom_range(21, 127)
                  : $signed($urandom_range(0, 138)) - 128, $urandom, $urandom, 0);

        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 1, none});
        plan.push_back('{REQ_SPARE, 4095, -1, 2047, 2047, 1, 0, none});
        plan.push_back('{REQ_WRITE, 4095, 127, 0, 0, 0, 0, none});
        plan.push_back('{REQ_WRITE, 0, -128, 0, 0, 0, 0, none});
        plan.push_back('{REQ_WRITE, 1300, 127, 0, 0, 0, 0, none});
        plan.push_back('{REQ_WRITE, 1301, -1, 0, 0, 0, 0, none});
        plan.push_back('{REQ_APPEND, 0, 0, 0, 0, 0, 0, none});
        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 1, none});
        plan.push_back('{REQ_APPEND, 0, 0, 5, 3, 0, 0, none});
        plan.push_back('{REQ_APPEND, 0, 0, 9, 9, 1, 0, none});
        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 0, none});
        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 0, none});
        // The middle point sits on a costly cell between its neighbours.
        plan.push_back('{REQ_APPEND, 0, 0, 19, 20, 0, 0, none});
        plan.push_back('{REQ_APPEND, 0, 0, 20, 20, 0, 0, none});
        plan.push_back('{REQ_APPEND, 0, 0, 21, 20, 0, 0, none});
        plan.push_back('{REQ_APPEND, 0, 0, 30, 22, 1, 0, none});
        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 0, none});
        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 0, none});
        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 0, none});
        // Corner to corner overruns the path buffer while densifying.
        plan.push_back('{REQ_APPEND, 0, 0, -2048, -2048, 0, 0, none});
        plan.push_back('{REQ_APPEND, 0, 0, 2047, 2047, 1, 0, none});
        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 0, none});
        plan.push_back('{REQ_APPEND, 0, 0, 7, 7, 1, 0, none});
        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 0, none});
        plan.push_back('{REQ_READ, 0, 0, 0, 0, 0, 1, none});
        foreach (plan[i])
        begin
            row = plan[i];
            issue(row.req, row.idx, row.cost, row.x, row.y, row.lst, row.typed, row.want);
        end
        drain();

        sent = 0;
        for (ph = 0; sent < 850; ph++)
        begin
            case (ph)
                0:
                begin
                    set_reg(CFG_WIDTH, 4096);
                    set_reg(CFG_HEIGHT, 4096);
                    set_reg(CFG_LIMIT, 127);
                    set_reg(CFG_PASSES, 15);
                end
                1:
                begin
                    set_reg(CFG_WIDTH, 1);
                    set_reg(CFG_HEIGHT, 1);
                    set_reg(CFG_LIMIT, -128);
                    set_reg(CFG_PASSES, 0);
                end
                2:
                begin
                    set_reg(CFG_WIDTH, 64);
                    set_reg(CFG_HEIGHT, 48);
                    set_reg(CFG_LIMIT, 0);
                    set_reg(CFG_PASSES, 1);
                end
                default:
                begin
                    set_reg(CFG_WIDTH, $urandom_range(1, 4096));
                    set_reg(CFG_HEIGHT, $urandom_range(1, 4096));
                    set_reg(CFG_LIMIT, $urandom_range(0, 255));
                    set_reg(CFG_PASSES, $urandom_range(0, 15));
                end
            endcase
            if (ph == 2)
            begin
                // One point past the buffer; the dropped point still carries the last mark.
                saved = sent;
                for (i = 0; i <= PATH_CAP; i++)
                    issue(REQ_APPEND, $urandom, $urandom, 10, 10, i == PATH_CAP);
                sent = saved;
                read_out(3);
            end
            for (paths = 0; paths < 12 && sent < 850; paths++)
                random_path();
            drain();
        end
        drain();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
